/* hdl/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that expr holds in the cycle after cond.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

/* hdl/ppfs_pkg.sv */
// Types and constants of the priority periodic flag scheduler.
package ppfs_pkg;

  localparam int TICK_RATE  = 1000;
  localparam int CHANNELS   = 9;
  localparam int RATE_COUNT = 9;
  localparam int TICK_W     = 32;

  localparam int ACTIVE_CHANNELS = (CHANNELS > RATE_COUNT) ? RATE_COUNT : CHANNELS;

  // Channel period in ticks, fastest channel first.
  localparam logic [TICK_W-1:0] PERIOD [RATE_COUNT] = '{
    TICK_W'(TICK_RATE / 1000),
    TICK_W'(TICK_RATE / 500),
    TICK_W'(TICK_RATE / 250),
    TICK_W'(TICK_RATE / 100),
    TICK_W'(TICK_RATE / 50),
    TICK_W'(TICK_RATE / 20),
    TICK_W'(TICK_RATE / 10),
    TICK_W'(TICK_RATE / 4),
    TICK_W'(TICK_RATE / 1)
  };

  typedef enum logic {
    MODE_RUN  = 1'b0,
    MODE_INIT = 1'b1
  } mode_e;

  typedef logic [RATE_COUNT-1:0][TICK_W-1:0] base_vec_t;

  typedef struct packed {
    logic [RATE_COUNT-1:0] rate_flags;
    logic                  any_fired;
  } result_t;

endpackage

/* hdl/ppfs_req_if.sv */
// Request channel: mode and current tick.
interface ppfs_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ppfs_pkg::TICK_W-1:0] tick_now;

  modport source (output valid, output mode, output tick_now, input ready);
  modport sink   (input valid, input mode, input tick_now, output ready);
endinterface

/* hdl/ppfs_rsp_if.sv */
// Response channel: fired rate flags and an any-fired flag.
interface ppfs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ppfs_pkg::RATE_COUNT-1:0] rate_flags;
  logic                            any_fired;

  modport source (output valid, output rate_flags, output any_fired, input ready);
  modport sink   (input valid, input rate_flags, input any_fired, output ready);
endinterface

/* hdl/ppfs_check.sv */
// Per-channel elapsed-time compare, priority pick and next due bases.
module ppfs_check (
  input  logic                        mode_i,
  input  logic [ppfs_pkg::TICK_W-1:0] tick_now_i,
  input  ppfs_pkg::base_vec_t         base_i,
  output ppfs_pkg::base_vec_t         base_o,
  output ppfs_pkg::result_t           result_o
);

  logic [ppfs_pkg::RATE_COUNT-1:0] hit;
  logic [ppfs_pkg::RATE_COUNT-1:0] first;

  for (genvar ch = 0; ch < ppfs_pkg::RATE_COUNT; ch++) begin : g_chan
    if (ch < ppfs_pkg::ACTIVE_CHANNELS) begin : g_on
      assign hit[ch] = (mode_i == ppfs_pkg::MODE_RUN) &&
                       ((tick_now_i - base_i[ch]) >= ppfs_pkg::PERIOD[ch]);
    end else begin : g_off
      assign hit[ch] = 1'b0;
    end

    always_comb begin
      if (mode_i == ppfs_pkg::MODE_INIT) begin
        base_o[ch] = tick_now_i;
      end else if (first[ch]) begin
        base_o[ch] = base_i[ch] + ppfs_pkg::PERIOD[ch];
      end else begin
        base_o[ch] = base_i[ch];
      end
    end
  end

  // keep the lowest set bit: fastest channel wins
  assign first = hit & (~hit + ppfs_pkg::RATE_COUNT'(1));

  assign result_o.rate_flags = first;
  assign result_o.any_fired  = |hit;

endmodule

/* hdl/priority_periodic_flag_scheduler.sv */
// An accepted request waits in the request register until the response register is free.
// Throughput: one request per cycle while responses are not stalled; the per-channel
//   subtract-compare and priority pick sit between the request register and the response register.
// The response register holds a result while the next request is taken.
// Reset: asynchronous, active low; clears all due bases to zero and both valid flags.
`include "assert_macros.svh"

module priority_periodic_flag_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppfs_req_if.sink          req_i,
  ppfs_rsp_if.source        rsp_o
);

  logic                        in_valid_q;
  logic                        in_mode_q;
  logic [ppfs_pkg::TICK_W-1:0] in_tick_q;

  logic                        out_valid_q;
  ppfs_pkg::result_t           out_q;

  ppfs_pkg::base_vec_t         base_q;
  ppfs_pkg::base_vec_t         base_d;
  ppfs_pkg::result_t           result_d;

  logic                        out_free;
  logic                        advance;
  logic                        accept;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  ppfs_check u_check (
    .mode_i     (in_mode_q),
    .tick_now_i (in_tick_q),
    .base_i     (base_q),
    .base_o     (base_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        base_q <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_mode_q <= req_i.mode;
      in_tick_q <= req_i.tick_now;
    end
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.rate_flags = out_q.rate_flags;
  assign rsp_o.any_fired  = out_q.any_fired;

  `ASSERT_AT(a_flags_consistent, clk_i, rst_ni,
    !out_valid_q || ($onehot0(out_q.rate_flags) && (out_q.any_fired == (out_q.rate_flags != '0))))

  `ASSERT_NEXT(a_init_loads_base, clk_i, rst_ni,
    advance && (in_mode_q == ppfs_pkg::MODE_INIT),
    (base_q[0] == $past(in_tick_q)) && !out_q.any_fired)

  `ASSERT_NEXT(a_idle_bases_hold, clk_i, rst_ni,
    !advance || ((in_mode_q == ppfs_pkg::MODE_RUN) && !result_d.any_fired),
    $stable(base_q))

endmodule
